@@ rtl/core/boot_keyboard_report_differ_macros.svh @@
// Assertion macros shared by the keyboard report differ
`ifndef BOOT_KEYBOARD_REPORT_DIFFER_MACROS_SVH
`define BOOT_KEYBOARD_REPORT_DIFFER_MACROS_SVH

// same-cycle implication
`define BKRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bkrd same-cycle check failed");

// next-cycle implication
`define BKRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bkrd next-cycle check failed");

`endif

@@ rtl/core/bkrd_pkg.sv @@
package bkrd_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int MOD_BITS  = 8;
    localparam int MASK_W    = MOD_BITS + 2 * KEY_SLOTS;

    typedef logic [7:0] t_usage;
    typedef logic [KEY_SLOTS*8-1:0] t_slots;
    typedef logic [MASK_W-1:0] t_mask;

    typedef struct packed {
        logic release_hit;
        logic press_hit;
    } t_lane_flags;

    localparam logic [1:0] EK_MOD     = 2'd0;
    localparam logic [1:0] EK_RELEASE = 2'd1;
    localparam logic [1:0] EK_PRESS   = 2'd2;

    localparam t_usage USE_CAPS   = 8'h39;
    localparam t_usage USE_NUM    = 8'h53;
    localparam t_usage USE_SCROLL = 8'h47;

    localparam logic [7:0] SHIFT_MASK = 8'h22;

    localparam logic [6:0] MOD_CODE [8] = '{7'd29, 7'd42, 7'd56, 7'd125,
                                            7'd97, 7'd54, 7'd100, 7'd126};

    function automatic logic [6:0] f_code(t_usage u);
        logic [6:0] c;
        c = '0;
        case (u)
            8'h04: c = 7'd30;  8'h05: c = 7'd48;  8'h06: c = 7'd46;  8'h07: c = 7'd32;
            8'h08: c = 7'd18;  8'h09: c = 7'd33;  8'h0A: c = 7'd34;  8'h0B: c = 7'd35;
            8'h0C: c = 7'd23;  8'h0D: c = 7'd36;  8'h0E: c = 7'd37;  8'h0F: c = 7'd38;
            8'h10: c = 7'd50;  8'h11: c = 7'd49;  8'h12: c = 7'd24;  8'h13: c = 7'd25;
            8'h14: c = 7'd16;  8'h15: c = 7'd19;  8'h16: c = 7'd31;  8'h17: c = 7'd20;
            8'h18: c = 7'd22;  8'h19: c = 7'd47;  8'h1A: c = 7'd17;  8'h1B: c = 7'd45;
            8'h1C: c = 7'd21;  8'h1D: c = 7'd44;  8'h1E: c = 7'd2;   8'h1F: c = 7'd3;
            8'h20: c = 7'd4;   8'h21: c = 7'd5;   8'h22: c = 7'd6;   8'h23: c = 7'd7;
            8'h24: c = 7'd8;   8'h25: c = 7'd9;   8'h26: c = 7'd10;  8'h27: c = 7'd11;
            8'h28: c = 7'd28;  8'h29: c = 7'd1;   8'h2A: c = 7'd14;  8'h2B: c = 7'd15;
            8'h2C: c = 7'd57;  8'h2D: c = 7'd12;  8'h2E: c = 7'd13;  8'h2F: c = 7'd26;
            8'h30: c = 7'd27;  8'h31: c = 7'd43;  8'h32: c = 7'd86;  8'h33: c = 7'd39;
            8'h34: c = 7'd40;  8'h35: c = 7'd41;  8'h36: c = 7'd51;  8'h37: c = 7'd52;
            8'h38: c = 7'd53;  8'h39: c = 7'd58;  8'h3A: c = 7'd59;  8'h3B: c = 7'd60;
            8'h3C: c = 7'd61;  8'h3D: c = 7'd62;  8'h3E: c = 7'd63;  8'h3F: c = 7'd64;
            8'h40: c = 7'd65;  8'h41: c = 7'd66;  8'h42: c = 7'd67;  8'h43: c = 7'd68;
            8'h44: c = 7'd87;  8'h45: c = 7'd88;  8'h46: c = 7'd99;  8'h47: c = 7'd70;
            8'h48: c = 7'd119; 8'h49: c = 7'd110; 8'h4A: c = 7'd102; 8'h4B: c = 7'd104;
            8'h4C: c = 7'd111; 8'h4D: c = 7'd107; 8'h4E: c = 7'd109; 8'h4F: c = 7'd106;
            8'h50: c = 7'd105; 8'h51: c = 7'd108; 8'h52: c = 7'd103; 8'h53: c = 7'd69;
            8'h54: c = 7'd98;  8'h55: c = 7'd55;  8'h56: c = 7'd74;  8'h57: c = 7'd78;
            8'h58: c = 7'd79;  8'h59: c = 7'd80;  8'h5A: c = 7'd81;  8'h5B: c = 7'd75;
            8'h5C: c = 7'd76;  8'h5D: c = 7'd77;  8'h5E: c = 7'd71;  8'h5F: c = 7'd72;
            8'h60: c = 7'd73;  8'h61: c = 7'd82;  8'h62: c = 7'd83;  8'h63: c = 7'd125;
            8'h64: c = 7'd126;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] f_char(t_usage u, logic shift, logic caps);
        logic       letter;
        logic       up;
        logic [6:0] c;
        letter = (u >= 8'h04) && (u <= 8'h1D);
        up     = shift ^ (caps && letter);
        c      = '0;
        if (letter) begin
            c = (up ? 7'd65 : 7'd97) + 7'(u - 8'h04);
        end else begin
            case (u)
                8'h1E: c = up ? 7'd33  : 7'd49;
                8'h1F: c = up ? 7'd64  : 7'd50;
                8'h20: c = up ? 7'd35  : 7'd51;
                8'h21: c = up ? 7'd36  : 7'd52;
                8'h22: c = up ? 7'd37  : 7'd53;
                8'h23: c = up ? 7'd94  : 7'd54;
                8'h24: c = up ? 7'd38  : 7'd55;
                8'h25: c = up ? 7'd42  : 7'd56;
                8'h26: c = up ? 7'd40  : 7'd57;
                8'h27: c = up ? 7'd41  : 7'd48;
                8'h28: c = 7'd10;
                8'h29: c = 7'd27;
                8'h2A: c = 7'd8;
                8'h2B: c = 7'd9;
                8'h2C: c = 7'd32;
                8'h2D: c = up ? 7'd95  : 7'd45;
                8'h2E: c = up ? 7'd43  : 7'd61;
                8'h2F: c = up ? 7'd123 : 7'd91;
                8'h30: c = up ? 7'd125 : 7'd93;
                8'h31: c = up ? 7'd124 : 7'd92;
                8'h32: c = up ? 7'd126 : 7'd35;
                8'h33: c = up ? 7'd58  : 7'd59;
                8'h34: c = up ? 7'd34  : 7'd39;
                8'h35: c = up ? 7'd126 : 7'd96;
                8'h36: c = up ? 7'd60  : 7'd44;
                8'h37: c = up ? 7'd62  : 7'd46;
                8'h38: c = up ? 7'd63  : 7'd47;
                8'h54: c = 7'd47;
                8'h55: c = 7'd42;
                8'h56: c = 7'd45;
                8'h57: c = 7'd43;
                8'h58: c = 7'd10;
                8'h59: c = 7'd49;
                8'h5A: c = 7'd50;
                8'h5B: c = 7'd51;
                8'h5C: c = 7'd52;
                8'h5D: c = 7'd53;
                8'h5E: c = 7'd54;
                8'h5F: c = 7'd55;
                8'h60: c = 7'd56;
                8'h61: c = 7'd57;
                8'h62: c = 7'd48;
                8'h63: c = 7'd46;
                8'h64: c = up ? 7'd124 : 7'd92;
                8'h67: c = 7'd61;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

@@ rtl/core/bkrd_if.sv @@
interface bkrd_rpt_if import bkrd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] report_modifiers;
    t_slots     key_slot;

    modport source (output valid, output report_modifiers, output key_slot, input ready);
    modport sink   (input valid, input report_modifiers, input key_slot, output ready);
endinterface

interface bkrd_evt_if import bkrd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    t_usage     key_usage;
    logic [6:0] event_code;
    logic       is_pressed;
    logic [7:0] modifiers_now;
    logic [6:0] ascii_char;
    logic [2:0] led_bits;
    logic       led_update;
    logic       last_event;

    modport source (output valid, output event_kind, output key_usage, output event_code,
                    output is_pressed, output modifiers_now, output ascii_char,
                    output led_bits, output led_update, output last_event, input ready);
    modport sink   (input valid, input event_kind, input key_usage, input event_code,
                    input is_pressed, input modifiers_now, input ascii_char,
                    input led_bits, input led_update, input last_event, output ready);
endinterface

@@ rtl/core/bkrd_lane.sv @@
module bkrd_lane import bkrd_pkg::*; (
    input  t_usage      i_old_key,
    input  t_usage      i_new_key,
    input  t_slots      i_old_keys,
    input  t_slots      i_new_keys,
    output t_lane_flags o_flags
);

    logic old_in_new;
    logic new_in_old;

    always_comb begin
        old_in_new = 1'b0;
        new_in_old = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if (i_new_keys[j*8 +: 8] == i_old_key) old_in_new = 1'b1;
            if (i_old_keys[j*8 +: 8] == i_new_key) new_in_old = 1'b1;
        end
        o_flags.release_hit = (i_old_key != '0) && !old_in_new;
        o_flags.press_hit   = (i_new_key != '0) && !new_in_old;
    end

endmodule

@@ rtl/core/bkrd_seq.sv @@
module bkrd_seq import bkrd_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bkrd_rpt_if.sink                     i_report,
    bkrd_evt_if.source                   o_event,
    input  t_lane_flags [KEY_SLOTS-1:0]  i_lane_flags,
    output t_slots                       o_old_keys,
    output t_slots                       o_new_keys
);

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_EMIT} t_state;

    t_state     r_state;
    t_slots     r_old_keys;
    t_slots     r_keys;
    logic [7:0] r_mods_old;
    logic [7:0] r_mods;
    t_mask      r_mask;
    logic       r_caps;
    logic       r_num;
    logic       r_scroll;

    logic       r_out_valid;
    logic [1:0] r_kind;
    t_usage     r_usage;
    logic [6:0] r_code;
    logic       r_pressed;
    logic [7:0] r_mods_now;
    logic [6:0] r_ascii;
    logic [2:0] r_leds;
    logic       r_upd;
    logic       r_last;

    t_mask      n_onehot;
    t_mask      n_mask;
    t_mask      n_load_mask;
    logic [2:0] n_mod_idx;
    t_usage     n_rel_usage;
    t_usage     n_prs_usage;
    logic       n_is_rel;
    logic       n_is_prs;
    logic [1:0] n_kind;
    t_usage     n_usage;
    logic [6:0] n_code;
    logic       n_pressed;
    logic [6:0] n_ascii;
    logic       n_caps;
    logic       n_num;
    logic       n_scroll;
    logic       n_upd;
    logic       out_free;

    assign out_free = !r_out_valid || o_event.ready;

    always_comb begin
        n_load_mask[MOD_BITS-1:0] = r_mods_old ^ r_mods;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            n_load_mask[MOD_BITS + i]             = i_lane_flags[i].release_hit;
            n_load_mask[MOD_BITS + KEY_SLOTS + i] = i_lane_flags[i].press_hit;
        end
    end

    always_comb begin
        n_onehot    = r_mask & (~r_mask + 1'b1);
        n_mask      = r_mask & (r_mask - 1'b1);
        n_mod_idx   = '0;
        n_rel_usage = '0;
        n_prs_usage = '0;
        for (int b = 0; b < MOD_BITS; b++) begin
            if (n_onehot[b]) n_mod_idx = n_mod_idx | 3'(b);
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (n_onehot[MOD_BITS + i]) n_rel_usage = n_rel_usage | r_old_keys[i*8 +: 8];
            if (n_onehot[MOD_BITS + KEY_SLOTS + i]) n_prs_usage = n_prs_usage | r_keys[i*8 +: 8];
        end
        n_is_rel = |n_onehot[MOD_BITS +: KEY_SLOTS];
        n_is_prs = |n_onehot[MOD_BITS + KEY_SLOTS +: KEY_SLOTS];

        n_caps   = r_caps;
        n_num    = r_num;
        n_scroll = r_scroll;
        n_upd    = 1'b0;
        n_ascii  = '0;

        if (n_is_prs) begin
            n_kind    = EK_PRESS;
            n_usage   = n_prs_usage;
            n_code    = f_code(n_prs_usage);
            n_pressed = 1'b1;
            if (n_prs_usage == USE_CAPS) begin
                n_caps = !r_caps;
                n_upd  = 1'b1;
            end else if (n_prs_usage == USE_NUM) begin
                n_num = !r_num;
                n_upd = 1'b1;
            end else if (n_prs_usage == USE_SCROLL) begin
                n_scroll = !r_scroll;
                n_upd    = 1'b1;
            end
            n_ascii = f_char(n_prs_usage, (r_mods & SHIFT_MASK) != '0, n_caps);
        end else if (n_is_rel) begin
            n_kind    = EK_RELEASE;
            n_usage   = n_rel_usage;
            n_code    = f_code(n_rel_usage);
            n_pressed = 1'b0;
        end else begin
            n_kind    = EK_MOD;
            n_usage   = {5'b0, n_mod_idx};
            n_code    = MOD_CODE[n_mod_idx];
            n_pressed = r_mods[n_mod_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_keys      <= '0;
            r_mods      <= '0;
            r_mask      <= '0;
            r_caps      <= 1'b0;
            r_num       <= 1'b0;
            r_scroll    <= 1'b0;
        end else begin
            if (o_event.ready && (r_state != S_EMIT)) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_report.valid) begin
                        r_old_keys <= r_keys;
                        r_keys     <= i_report.key_slot;
                        r_mods_old <= r_mods;
                        r_mods     <= i_report.report_modifiers;
                        r_state    <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_mask  <= n_load_mask;
                    r_state <= (n_load_mask != '0) ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= n_kind;
                        r_usage     <= n_usage;
                        r_code      <= n_code;
                        r_pressed   <= n_pressed;
                        r_mods_now  <= r_mods;
                        r_ascii     <= n_ascii;
                        r_leds      <= {n_scroll, n_caps, n_num};
                        r_upd       <= n_upd;
                        r_last      <= (n_mask == '0);
                        r_caps      <= n_caps;
                        r_num       <= n_num;
                        r_scroll    <= n_scroll;
                        r_mask      <= n_mask;
                        if (n_mask == '0) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_report.ready        = (r_state == S_IDLE);
    assign o_event.valid         = r_out_valid;
    assign o_event.event_kind    = r_kind;
    assign o_event.key_usage     = r_usage;
    assign o_event.event_code    = r_code;
    assign o_event.is_pressed    = r_pressed;
    assign o_event.modifiers_now = r_mods_now;
    assign o_event.ascii_char    = r_ascii;
    assign o_event.led_bits      = r_leds;
    assign o_event.led_update    = r_upd;
    assign o_event.last_event    = r_last;

    assign o_old_keys = r_old_keys;
    assign o_new_keys = r_keys;

endmodule

@@ rtl/core/boot_keyboard_report_differ.sv @@
// The report is registered in S_IDLE, its change mask in S_LOAD, each event in S_EMIT.
// A report causes up to 8 + 2*KEY_SLOTS events; with none it returns to S_IDLE.
// The output word register issues one event per cycle unless o_event.ready stalls it.
// Reset: synchronous, active low; clears stored keys, modifiers and lock flags.
`include "boot_keyboard_report_differ_macros.svh"

module boot_keyboard_report_differ import bkrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bkrd_rpt_if.sink    i_report,
    bkrd_evt_if.source  o_event
);

    t_lane_flags [KEY_SLOTS-1:0] lane_flags;
    t_slots                      old_keys;
    t_slots                      new_keys;

    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
        bkrd_lane u_lane (
            .i_old_key  (old_keys[g*8 +: 8]),
            .i_new_key  (new_keys[g*8 +: 8]),
            .i_old_keys (old_keys),
            .i_new_keys (new_keys),
            .o_flags    (lane_flags[g])
        );
    end

    bkrd_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_report     (i_report),
        .o_event      (o_event),
        .i_lane_flags (lane_flags),
        .o_old_keys   (old_keys),
        .o_new_keys   (new_keys)
    );

    `BKRD_ASSERT_NOW(a_busy_mid_report, i_clk, i_rst_n, o_event.valid && !o_event.last_event, !i_report.ready)
    `BKRD_ASSERT_NOW(a_led_on_press, i_clk, i_rst_n, o_event.valid && o_event.led_update, (o_event.event_kind == EK_PRESS) && o_event.is_pressed)
    `BKRD_ASSERT_NEXT(a_no_back_to_back, i_clk, i_rst_n, i_report.valid && i_report.ready, !i_report.ready)

endmodule
